/* rtl/core/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher block.
// Used by the register file, controller, datapath and top level.
`default_nettype none

package rc4_pkg;

  localparam int PERM_SIZE     = 256;
  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;
  localparam int KEY_LEN_W     = 6;
  localparam int APB_ADDR_W    = 6;
  localparam int APB_DATA_W    = 64;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  typedef enum logic [2:0] {
    REG_KEY_LEN = 3'd0,
    REG_KEY_W0  = 3'd1,
    REG_KEY_W1  = 3'd2,
    REG_KEY_W2  = 3'd3,
    REG_KEY_W3  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_KS_RD_I,
    S_KS_RD_J,
    S_KS_WR_I,
    S_KS_WR_J,
    S_PG_RD_I,
    S_PG_RD_J,
    S_PG_WR_I,
    S_PG_WR_J,
    S_OUT_WAIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_INIT_WR,
    DP_KS_RD_I,
    DP_KS_RD_J,
    DP_KS_WR_I,
    DP_KS_WR_J,
    DP_PG_RD_I,
    DP_PG_RD_J,
    DP_PG_WR_I,
    DP_PG_WR_J,
    DP_HOLD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [KEY_LEN_W-1:0] len);
    logic [KEY_LEN_W-1:0] r;
    r = len;
    if (len == '0) begin
      r = KEY_LEN_W'(1);
    end else if (len > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      r = KEY_LEN_W'(MAX_KEY_BYTES);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rc4_stream_cipher.sv */
// RC4 stream cipher top level: register file, controller and datapath.
// Depends on rc4_pkg, rc4_regs, rc4_ctrl and rc4_dp.
//
// Each input request carries one data byte with start and end flags; each
// gives one output request with the byte XORed with the next keystream byte
// and the end flag copied. A request with message_start set, or any request
// before the first key schedule since reset, first runs the key schedule:
// it loads the identity permutation, then mixes every entry with a swap of
// two reads and two writes on the permutation memory, then fetches the entry
// at the advanced index.
// Without a key schedule a request goes through the read, read, write, write
// sequence of the swap on the permutation memory before its output byte is
// loaded, and no new request is accepted until the previous one is done.
// The output register holds a finished byte while out_stall is high; the
// block then holds in_stall high until the byte can be loaded.
// Reset clears the indices, marks the block as unkeyed, empties the output
// register and restores key_length to 16 and the key words to zero. Users write
// key registers on the APB port only while the block is idle (not enforced).
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  message_start,
  input  wire logic                  message_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [7:0]            out_byte,
  output logic                       out_end
);

  logic [KEY_LEN_W-1:0] key_length;
  logic [KEY_BITS-1:0]  key_vec;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  rc4_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_length (key_length),
    .key_vec    (key_vec)
  );

  rc4_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .message_start (message_start),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .stat          (stat)
  );

  rc4_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key_length  (key_length),
    .key_vec     (key_vec),
    .data_byte   (data_byte),
    .message_end (message_end),
    .out_byte    (out_byte),
    .out_end     (out_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous request still in progress");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("output load did not raise out_valid");

  a_output_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output appeared with no request in progress");

endmodule

`default_nettype wire

/* rtl/core/rc4_regs.sv */
// Configuration register file on the APB-style port.
// Depends on rc4_pkg for the register map and widths.
`default_nettype none

module rc4_regs
  import rc4_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [KEY_LEN_W-1:0]  key_length,
  output logic      [KEY_BITS-1:0]   key_vec
);

  logic [APB_DATA_W-1:0] key_w0, key_w1, key_w2, key_w3;
  reg_idx_t              reg_idx;
  logic                  wr_en;

  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign key_vec = {key_w3, key_w2, key_w1, key_w0};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
      key_w0     <= '0;
      key_w1     <= '0;
      key_w2     <= '0;
      key_w3     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LEN: key_length <= pwdata[KEY_LEN_W-1:0];
        REG_KEY_W0:  key_w0 <= pwdata;
        REG_KEY_W1:  key_w1 <= pwdata;
        REG_KEY_W2:  key_w2 <= pwdata;
        REG_KEY_W3:  key_w3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LEN: prdata = {{(APB_DATA_W-KEY_LEN_W){1'b0}}, key_length};
      REG_KEY_W0:  prdata = key_w0;
      REG_KEY_W1:  prdata = key_w1;
      REG_KEY_W2:  prdata = key_w2;
      REG_KEY_W3:  prdata = key_w3;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rc4_ctrl.sv */
// Controller state machine sequencing key schedule and keystream steps.
// Depends on rc4_pkg for the state, command and status types.
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     message_start,
  output logic          in_stall,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  ctrl_state_t state, state_next;
  logic        keyed, keyed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      keyed <= 1'b0;
    end else begin
      state <= state_next;
      keyed <= keyed_next;
    end
  end

  always_comb begin
    state_next   = state;
    keyed_next   = keyed;
    in_stall     = 1'b1;
    cmd.op       = DP_HOLD;
    cmd.capture  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.op   = DP_IDLE;
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (message_start || !keyed) ? S_INIT : S_PG_RD_J;
        end
      end
      S_INIT: begin
        cmd.op = DP_INIT_WR;
        if (stat.cnt_last) begin
          state_next = S_KS_RD_I;
        end
      end
      S_KS_RD_I: begin
        cmd.op     = DP_KS_RD_I;
        state_next = S_KS_RD_J;
      end
      S_KS_RD_J: begin
        cmd.op     = DP_KS_RD_J;
        state_next = S_KS_WR_I;
      end
      S_KS_WR_I: begin
        cmd.op     = DP_KS_WR_I;
        state_next = S_KS_WR_J;
      end
      S_KS_WR_J: begin
        cmd.op = DP_KS_WR_J;
        if (stat.cnt_last) begin
          keyed_next = 1'b1;
          state_next = S_PG_RD_I;
        end else begin
          state_next = S_KS_RD_I;
        end
      end
      S_PG_RD_I: begin
        cmd.op     = DP_PG_RD_I;
        state_next = S_PG_RD_J;
      end
      S_PG_RD_J: begin
        cmd.op     = DP_PG_RD_J;
        state_next = S_PG_WR_I;
      end
      S_PG_WR_I: begin
        cmd.op     = DP_PG_WR_I;
        state_next = S_PG_WR_J;
      end
      S_PG_WR_J: begin
        cmd.op       = DP_PG_WR_J;
        cmd.load_out = stat.out_free;
        state_next   = stat.out_free ? S_IDLE : S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rc4_dp.sv */
// Datapath: permutation memory, indices, key byte selection and output register.
// Depends on rc4_pkg for the command and status types and constants.
`default_nettype none

module rc4_dp
  import rc4_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic [KEY_LEN_W-1:0] key_length,
  input  wire logic [KEY_BITS-1:0]  key_vec,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 message_end,
  output logic      [7:0]           out_byte,
  output logic                      out_end,
  output logic                      out_valid,
  input  wire logic                 out_stall
);

  logic [7:0]           mem [PERM_SIZE];
  logic [7:0]           rd_data;
  logic [7:0]           rd_addr;
  logic                 mem_we;
  logic [7:0]           mem_wa;
  logic [7:0]           mem_wd;

  logic [7:0]           cnt;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [7:0]           ks_j;
  logic [7:0]           idx_i;
  logic [7:0]           idx_j;
  logic [7:0]           si;
  logic [7:0]           sj;
  logic [7:0]           t_addr;
  logic [7:0]           data_reg;
  logic                 end_reg;
  logic [7:0]           res_byte;

  logic [7:0]           key_byte;
  logic [7:0]           ks_j_new;
  logic [7:0]           pg_j_new;
  logic [7:0]           t_new;
  logic [7:0]           ks_val;
  logic [7:0]           res_comb;
  logic [KEY_LEN_W-1:0] len_eff;
  logic                 key_wrap;

  assign key_byte = key_vec[{key_idx, 3'b000} +: 8];
  assign ks_j_new = ks_j + rd_data + key_byte;
  assign pg_j_new = idx_j + rd_data;
  assign t_new    = si + rd_data;
  assign len_eff  = eff_key_len(key_length);
  assign key_wrap = (KEY_LEN_W'(key_idx) + KEY_LEN_W'(1)) >= len_eff;
  assign ks_val   = (t_addr == idx_j) ? si : ((t_addr == idx_i) ? sj : rd_data);
  assign res_comb = data_reg ^ ks_val;

  assign stat.cnt_last = (cnt == 8'hFF);
  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = cnt;
    mem_wd  = cnt;
    rd_addr = idx_i + 8'd1;
    unique case (cmd.op) inside
      DP_IDLE, DP_PG_RD_I: rd_addr = idx_i + 8'd1;
      DP_INIT_WR: mem_we = 1'b1;
      DP_KS_RD_I: rd_addr = cnt;
      DP_KS_RD_J: rd_addr = ks_j_new;
      DP_KS_WR_I: begin
        mem_we = 1'b1;
        mem_wd = rd_data;
      end
      DP_KS_WR_J: begin
        mem_we = 1'b1;
        mem_wa = ks_j;
        mem_wd = si;
      end
      DP_PG_RD_J: rd_addr = pg_j_new;
      DP_PG_WR_I: begin
        mem_we  = 1'b1;
        mem_wa  = idx_i;
        mem_wd  = rd_data;
        rd_addr = t_new;
      end
      DP_PG_WR_J: begin
        mem_we = 1'b1;
        mem_wa = idx_j;
        mem_wd = si;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      key_idx <= '0;
      ks_j    <= '0;
      idx_i   <= '0;
      idx_j   <= '0;
    end else begin
      unique case (cmd.op)
        DP_INIT_WR: begin
          cnt     <= cnt + 8'd1;
          key_idx <= '0;
          ks_j    <= '0;
          idx_i   <= '0;
          idx_j   <= '0;
        end
        DP_KS_RD_J: ks_j <= ks_j_new;
        DP_KS_WR_J: begin
          cnt     <= cnt + 8'd1;
          key_idx <= key_wrap ? '0 : key_idx + KEY_IDX_W'(1);
        end
        DP_PG_RD_J: begin
          idx_i <= idx_i + 8'd1;
          idx_j <= pg_j_new;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      data_reg <= data_byte;
      end_reg  <= message_end;
    end
    if (cmd.op == DP_KS_RD_J || cmd.op == DP_PG_RD_J) begin
      si <= rd_data;
    end
    if (cmd.op == DP_PG_WR_I) begin
      sj     <= rd_data;
      t_addr <= t_new;
    end
    if (cmd.op == DP_PG_WR_J) begin
      res_byte <= res_comb;
    end
    if (cmd.load_out) begin
      out_byte <= (cmd.op == DP_PG_WR_J) ? res_comb : res_byte;
      out_end  <= end_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sim/tb_rc4_stream_cipher.sv */
// Self-checking testbench for rc4_stream_cipher: a directed table, then random messages.
// Depends on rc4_pkg and the rc4_stream_cipher RTL; results are checked against an
// in-bench RC4 predictor and a known test vector.
`timescale 1ns / 100ps

module tb_rc4_stream_cipher
  import rc4_pkg::*;
();

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_sel;
    logic [63:0] value;
    logic [7:0]  data;
    logic        start;
    logic        fin;
    logic        known;
    logic [7:0]  known_b;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] out_b;
    logic       fin;
  } cipher_out_t;

  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 280;
  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  message_start = 1'b0;
  logic                  message_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  out_end;

  rc4_stream_cipher dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .message_start(message_start), .message_end(message_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_end(out_end)
  );

  always #1 clk = ~clk;

  logic [7:0]  sbox [256];
  logic [7:0]  ks_i = 8'h00;
  logic [7:0]  ks_j = 8'h00;
  logic        is_keyed = 1'b0;
  logic [5:0]  cfg_key_len = KEY_LEN_RESET;
  logic [63:0] cfg_key [4] = '{default: 64'h0};

  cipher_out_t expected_q[$];
  stim_row_t   dir_rows[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  function automatic void run_key_schedule();
    int n;
    int len;
    int kpos;
    logic [7:0] j;
    logic [7:0] t;
    len = (cfg_key_len == 0) ? 1 :
          (cfg_key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(cfg_key_len);
    for (n = 0; n < 256; n++) sbox[n] = 8'(n);
    j = 8'h00;
    kpos = 0;
    for (n = 0; n < 256; n++) begin
      j = j + sbox[n] + cfg_key[kpos >> 3][(kpos & 7) * 8 +: 8];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
      kpos = (kpos + 1 == len) ? 0 : kpos + 1;
    end
    ks_i = 8'h00;
    ks_j = 8'h00;
    is_keyed = 1'b1;
  endfunction

  function automatic cipher_out_t predict_cipher(logic [7:0] d, logic s, logic e);
    cipher_out_t r;
    logic [7:0] t;
    logic [7:0] sum;
    if (s || !is_keyed) run_key_schedule();
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    t = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = t;
    sum = sbox[ks_i] + sbox[ks_j];
    r.out_b = d ^ sbox[sum];
    r.fin = e;
    return r;
  endfunction

  function automatic void cfg_row(logic [2:0] idx, logic [63:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, reg_sel: idx, value: val, default: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void item_row(logic [7:0] d, logic s, logic e, logic known,
                                   logic [7:0] kb);
    stim_row_t row;
    row = '{kind: ROW_ITEM, reg_sel: 3'd0, value: 64'h0, data: d, start: s, fin: e,
            known: known, known_b: kb};
    dir_rows.push_back(row);
  endfunction

  task automatic offer(logic [7:0] d, logic s, logic e, logic known, logic [7:0] kb);
    cipher_out_t exp_out;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    message_start <= s;
    message_end <= e;
    do @(posedge clk); while (in_stall);
    exp_out = predict_cipher(d, s, e);
    if (known) exp_out.out_b = kb;
    expected_q.push_back(exp_out);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_LEN: cfg_key_len = val[5:0];
      REG_KEY_W0:  cfg_key[0] = val;
      REG_KEY_W1:  cfg_key[1] = val;
      REG_KEY_W2:  cfg_key[2] = val;
      REG_KEY_W3:  cfg_key[3] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cipher_out_t exp_out;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected output request: out_byte=%02h out_end=%0b", out_byte, out_end);
        mismatch_count++;
      end else begin
        exp_out = expected_q.pop_front();
        if (out_byte !== exp_out.out_b) begin
          $error("out_byte: expected %02h, actual %02h", exp_out.out_b, out_byte);
          mismatch_count++;
        end
        if (out_end !== exp_out.fin) begin
          $error("out_end: expected %0b, actual %0b", exp_out.fin, out_end);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rx_mode_t mode;
    int left;
    int hold_cnt;
    int tick;
    mode = RX_FREE;
    left = 0;
    hold_cnt = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= 1'($urandom_range(0, 1));
          default:  out_stall <= (tick % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int p;
    int k;
    int sent;
    int msg_len;
    bit broken;
    bit cont;
    logic s;
    logic e;
    logic [5:0] len_val;

    // Reset key, no schedule run yet, so the first request keys the store itself.
    item_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    item_row(8'hFF, 1'b0, 1'b1, 1'b0, 8'h00);
    item_row(8'h5A, 1'b0, 1'b0, 1'b0, 8'h00);
    item_row(8'hA5, 1'b1, 1'b1, 1'b0, 8'h00);
    // Three-byte key "Key"; the set bits in word one lie beyond the key length.
    cfg_row(REG_KEY_LEN, 64'd3);
    cfg_row(REG_KEY_W0, 64'h0000_0000_0079_654B);
    cfg_row(REG_KEY_W1, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_row(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    item_row(8'h50, 1'b1, 1'b0, 1'b1, 8'hBB);
    item_row(8'h6C, 1'b0, 1'b0, 1'b1, 8'hF3);
    item_row(8'h61, 1'b0, 1'b0, 1'b1, 8'h16);
    item_row(8'h69, 1'b0, 1'b0, 1'b1, 8'hE8);
    item_row(8'h6E, 1'b0, 1'b0, 1'b1, 8'hD9);
    item_row(8'h74, 1'b0, 1'b0, 1'b1, 8'h40);
    item_row(8'h65, 1'b0, 1'b0, 1'b1, 8'hAF);
    item_row(8'h78, 1'b0, 1'b0, 1'b1, 8'h0A);
    item_row(8'h74, 1'b0, 1'b1, 1'b1, 8'hD3);
    // Zero key length acts as one; the first request still uses the old keystream.
    cfg_row(REG_KEY_LEN, 64'd0);
    cfg_row(REG_KEY_W0, 64'hFFFF_FFFF_FFFF_FFFF);
    item_row(8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    item_row(8'h00, 1'b1, 1'b0, 1'b0, 8'h00);
    item_row(8'hFF, 1'b0, 1'b1, 1'b0, 8'h00);
    cfg_row(REG_KEY_LEN, 64'd63);
    cfg_row(REG_KEY_W1, 64'h0123_4567_89AB_CDEF);
    cfg_row(REG_KEY_W2, 64'hFEDC_BA98_7654_3210);
    cfg_row(REG_KEY_W3, 64'h8000_0000_0000_0001);
    item_row(8'h80, 1'b1, 1'b0, 1'b0, 8'h00);
    item_row(8'h01, 1'b0, 1'b1, 1'b0, 8'h00);
    cfg_row(REG_KEY_LEN, 64'd32);
    item_row(8'h7F, 1'b1, 1'b1, 1'b0, 8'h00);
    item_row(8'hC3, 1'b1, 1'b0, 1'b0, 8'h00);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        apb_write(dir_rows[r].reg_sel, dir_rows[r].value);
      end else begin
        offer(dir_rows[r].data, dir_rows[r].start, dir_rows[r].fin,
              dir_rows[r].known, dir_rows[r].known_b);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: len_val = 6'd1;
        1: len_val = 6'd32;
        2: len_val = 6'd0;
        3: len_val = 6'd63;
        default: len_val = 6'($urandom_range(0, 63));
      endcase
      apb_write(REG_KEY_LEN, {58'h0, len_val});
      apb_write(REG_KEY_W0, {$urandom, $urandom});
      apb_write(REG_KEY_W1, {$urandom, $urandom});
      apb_write(REG_KEY_W2, {$urandom, $urandom});
      apb_write(REG_KEY_W3, {$urandom, $urandom});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90)
                                               : $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        cont = ($urandom_range(0, 5) == 0);
        for (k = 0; k < msg_len; k++) begin
          if (broken) begin
            s = ($urandom_range(0, 7) == 0);
            e = 1'($urandom_range(0, 1));
          end else begin
            s = (k == 0) && !cont;
            e = (k == msg_len - 1);
          end
          offer(8'($urandom_range(0, 255)), s, e, 1'b0, 8'h00);
          sent++;
          if (p == 2 && sent == 100) hold_req = 1'b1;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
